FILE: design/integer_to_ascii_formatter_top_macros.svh
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_top_macros.svh
// assertion macros shared by the formatter modules
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_FORMATTER_TOP_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define ITOA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("itoa assertion failed");

// next-cycle implication, checked out of reset
`define ITOA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("itoa assertion failed");

`endif

FILE: design/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg
// types and constants of the integer to ascii formatter
// ----------------------------------------------------------------------------
`default_nettype none

package itoa_pkg;

  // command codes
  localparam logic [2:0] CMD_UDEC16 = 3'd0;
  localparam logic [2:0] CMD_SDEC16 = 3'd1;
  localparam logic [2:0] CMD_UDEC32 = 3'd2;
  localparam logic [2:0] CMD_SDEC32 = 3'd3;
  localparam logic [2:0] CMD_HEX16  = 3'd4;
  localparam logic [2:0] CMD_BIN16  = 3'd5;

  // ascii constants
  localparam logic [6:0] ASCII_ZERO  = 7'h30;
  localparam logic [6:0] ASCII_ONE   = 7'h31;
  localparam logic [6:0] ASCII_MINUS = 7'h2D;
  localparam logic [6:0] ASCII_ALPHA = 7'h37;

  // decimal digits of a 32-bit value
  localparam int unsigned NumDigits = 10;

  typedef logic [NumDigits-1:0][3:0] bcd_t;

  // controls into the conversion unit
  typedef struct packed {
    logic        start;
    logic        half;
    logic [31:0] value;
  } dab_ctrl_t;

  // status out of the conversion unit
  typedef struct packed {
    logic done;
    bcd_t bcd;
  } dab_stat_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CONV = 3'b010,
    S_EMIT = 3'b100
  } state_e;

endpackage

`default_nettype wire

FILE: design/itoa_dabble.sv
// ----------------------------------------------------------------------------
// itoa_dabble
// shift-and-add-3 binary to bcd converter, one input bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module itoa_dabble (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  itoa_pkg::dab_ctrl_t  ctrl_i,
  output itoa_pkg::dab_stat_t  stat_o
);
  import itoa_pkg::*;

  `include "integer_to_ascii_formatter_top_macros.svh"

  logic        active_q, active_d;
  logic        done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [31:0] bin_q, bin_d;
  bcd_t        bcd_q, bcd_d;
  bcd_t        bcd_adj;

  // add 3 to every digit of 5 or more
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      bcd_adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
    end
  end

  // iteration control
  always_comb begin
    active_d = active_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    bin_d    = bin_q;
    bcd_d    = bcd_q;
    if (ctrl_i.start) begin
      active_d = 1'b1;
      cnt_d    = ctrl_i.half ? 6'd16 : 6'd32;
      bin_d    = ctrl_i.value;
      bcd_d    = '0;
    end else if (active_q) begin
      {bcd_d, bin_d} = {bcd_adj, bin_q} << 1;
      cnt_d          = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      cnt_q    <= cnt_d;
    end
  end

  // data registers
  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign stat_o.done = done_q;
  assign stat_o.bcd  = bcd_q;

  `ITOA_ASSERT_IMPL(a_done_after_run, done_q, $past(active_q) && !active_q)
  `ITOA_ASSERT_IMPL(a_cnt_in_range, active_q, cnt_q != 6'd0 && cnt_q <= 6'd32)
  `ITOA_ASSERT_NEXT(a_start_runs, ctrl_i.start, active_q && !done_q)

endmodule

`default_nettype wire

FILE: design/integer_to_ascii_formatter_top.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_top
// formats a 32-bit value as ascii decimal, hex or binary characters
// ----------------------------------------------------------------------------
//  channel  | ports                          | handshake
//  ---------+--------------------------------+-------------------------------
//  command  | command_i, value_i             | start_i high while busy_o low
//  result   | character_o, last_o            | strobe_o, one cycle, no stall
//
// decimal modes: the 16-bit or 32-bit magnitude is shifted through the shift-and-add-3
// unit until it signals done, then characters go out at one per cycle, sign included
// hex and binary: no conversion, 4 or 16 characters at one per cycle
// busy_o rises after the accept and drops with the final character
// results leave through output registers; the receiver cannot stall the block
// reset clears the sequencer and the result strobe
// unused command codes are taken and produce no transaction
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_ascii_formatter_top (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        start_i,
  output logic       busy_o,
  input  wire  [2:0] command_i,
  input  wire [31:0] value_i,
  output logic       strobe_o,
  output logic [6:0] character_o,
  output logic       last_o
);
  import itoa_pkg::*;

  `include "integer_to_ascii_formatter_top_macros.svh"

  state_e      state_q, state_d;
  logic [2:0]  cmd_q, cmd_d;
  logic        neg_q, neg_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [15:0] hold_q, hold_d;
  logic        strobe_q, strobe_d;
  logic [6:0]  char_q, char_d;
  logic        last_q, last_d;

  dab_ctrl_t   dab_ctrl;
  dab_stat_t   dab_stat;

  logic        neg16, neg32;
  logic [15:0] mag16;
  logic [31:0] mag32;
  logic [3:0]  lead;
  logic [3:0]  nib;

  // shared bcd conversion unit
  itoa_dabble u_dabble (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (dab_ctrl),
    .stat_o (dab_stat)
  );

  // sign and magnitude of the incoming value
  assign neg16 = value_i[15];
  assign neg32 = value_i[31];
  assign mag16 = (command_i == CMD_SDEC16 && neg16) ? 16'(16'd0 - value_i[15:0])
                                                     : value_i[15:0];
  assign mag32 = (command_i == CMD_SDEC32 && neg32) ? 32'd0 - value_i : value_i;

  // most significant nonzero digit
  always_comb begin
    lead = 4'd0;
    for (int i = 0; i < NumDigits; i++) begin
      if (dab_stat.bcd[i] != 4'd0) begin
        lead = 4'(i);
      end
    end
  end

  assign nib = hold_q[15:12];

  // sequencer
  always_comb begin
    state_d        = state_q;
    cmd_d          = cmd_q;
    neg_d          = neg_q;
    cnt_d          = cnt_q;
    hold_d         = hold_q;
    strobe_d       = 1'b0;
    char_d         = char_q;
    last_d         = last_q;
    dab_ctrl.start = 1'b0;
    dab_ctrl.half  = 1'b0;
    dab_ctrl.value = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_d = command_i;
          neg_d = 1'b0;
          case (command_i)
            CMD_UDEC16, CMD_SDEC16: begin
              dab_ctrl.start = 1'b1;
              dab_ctrl.half  = 1'b1;
              dab_ctrl.value = {mag16, 16'd0};
              neg_d          = (command_i == CMD_SDEC16) && neg16;
              state_d        = S_CONV;
            end
            CMD_UDEC32, CMD_SDEC32: begin
              dab_ctrl.start = 1'b1;
              dab_ctrl.value = mag32;
              neg_d          = (command_i == CMD_SDEC32) && neg32;
              state_d        = S_CONV;
            end
            CMD_HEX16: begin
              hold_d  = value_i[15:0];
              cnt_d   = 4'd3;
              state_d = S_EMIT;
            end
            CMD_BIN16: begin
              hold_d  = value_i[15:0];
              cnt_d   = 4'd15;
              state_d = S_EMIT;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_CONV: begin
        if (dab_stat.done) begin
          cnt_d   = lead;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        strobe_d = 1'b1;
        last_d   = 1'b0;
        if (neg_q) begin
          // sign goes out ahead of the digits
          char_d = ASCII_MINUS;
          neg_d  = 1'b0;
        end else begin
          case (cmd_q)
            CMD_HEX16: begin
              char_d = (nib >= 4'd10) ? ASCII_ALPHA + {3'd0, nib} : ASCII_ZERO + {3'd0, nib};
              hold_d = hold_q << 4;
            end
            CMD_BIN16: begin
              char_d = hold_q[0] ? ASCII_ONE : ASCII_ZERO;
              hold_d = hold_q >> 1;
            end
            default: begin
              char_d = ASCII_ZERO + {3'd0, dab_stat.bcd[cnt_q]};
            end
          endcase
          last_d = (cnt_q == 4'd0);
          if (cnt_q == 4'd0) begin
            state_d = S_IDLE;
          end else begin
            cnt_d = cnt_q - 4'd1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      strobe_q <= strobe_d;
    end
  end

  // data registers
  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    neg_q  <= neg_d;
    cnt_q  <= cnt_d;
    hold_q <= hold_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign busy_o      = (state_q != S_IDLE);
  assign strobe_o    = strobe_q;
  assign character_o = char_q;
  assign last_o      = last_q & strobe_q;

  `ITOA_ASSERT_IMPL(a_strobe_from_emit, strobe_q, $past(state_q == S_EMIT))
  `ITOA_ASSERT_IMPL(a_done_in_conv, dab_stat.done, state_q == S_CONV)
  `ITOA_ASSERT_NEXT(a_last_ends_run, state_q == S_EMIT && !neg_q && cnt_q == 4'd0,
                    state_q == S_IDLE && last_o)

endmodule

`default_nettype wire

FILE: test/tb_integer_to_ascii_formatter_top.sv
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_formatter_top
// self-checking bench for the integer to ascii formatter
// ----------------------------------------------------------------------------
// A short table of directed commands is applied first: zero, the largest and
// most negative values of every mode, ignored upper halves, hex letters,
// binary bit order and the unused command codes. Some rows carry the text
// they should produce; the others, and a long random run after them, are
// checked against a behavioral formatter kept in the bench. Every character
// strobe is compared with the oldest expected character and its last flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_integer_to_ascii_formatter_top;

  import itoa_pkg::*;

  // command codes the block takes but ignores
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;

  localparam int unsigned RandomItems = 340;
  localparam int unsigned QuietTail   = 60;
  localparam int unsigned DrainCycles = 64;

  typedef struct packed {
    logic [6:0] character;
    logic       last;
  } out_char_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [2:0]  command_i;
  logic [31:0] value_i;
  logic        strobe_o;
  logic [6:0]  character_o;
  logic        last_o;

  out_char_t   expected_chars[$];
  logic [2:0]  row_cmd[$];
  logic [31:0] row_val[$];
  string       row_text[$];

  int unsigned fail_count     = 0;
  int unsigned accepted_count = 0;
  int unsigned char_count     = 0;
  int unsigned random_sent    = 0;
  bit          idle_on        = 1'b1;

  integer_to_ascii_formatter_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .command_i   (command_i),
    .value_i     (value_i),
    .strobe_o    (strobe_o),
    .character_o (character_o),
    .last_o      (last_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #200000;
    $display("CHECKS FAILED");
    $finish;
  end

  // formats one command into the characters it should produce
  function automatic void format_chars(input logic [2:0] cmd, input logic [31:0] val);
    logic [6:0]  chars[$];
    logic [3:0]  digits[$];
    logic [31:0] mag;
    logic [3:0]  nib;
    bit          decimal;
    int          k;
    decimal = 1'b0;
    mag     = '0;
    case (cmd)
      CMD_UDEC16: begin
        mag     = {16'h0, val[15:0]};
        decimal = 1'b1;
      end
      CMD_SDEC16: begin
        if (val[15]) begin
          chars.push_back(ASCII_MINUS);
          mag = {16'h0, 16'h0 - val[15:0]};
        end else begin
          mag = {16'h0, val[15:0]};
        end
        decimal = 1'b1;
      end
      CMD_UDEC32: begin
        mag     = val;
        decimal = 1'b1;
      end
      CMD_SDEC32: begin
        if (val[31]) begin
          chars.push_back(ASCII_MINUS);
          mag = 32'h0 - val;
        end else begin
          mag = val;
        end
        decimal = 1'b1;
      end
      CMD_HEX16: begin
        for (k = 0; k < 4; k++) begin
          nib = val[15 - 4*k -: 4];
          chars.push_back((nib >= 4'd10) ? ({3'b0, nib} + ASCII_ALPHA)
                                         : ({3'b0, nib} + ASCII_ZERO));
        end
      end
      CMD_BIN16: begin
        for (k = 0; k < 16; k++) begin
          chars.push_back(val[k] ? ASCII_ONE : ASCII_ZERO);
        end
      end
      default: ;
    endcase
    // decimal digits, most significant first, no leading zeros
    if (decimal) begin
      do begin
        digits.push_front(4'(mag % 10));
        mag = mag / 10;
      end while (mag != 0);
      for (k = 0; k < digits.size(); k++) begin
        chars.push_back(ASCII_ZERO + {3'b0, digits[k]});
      end
    end
    for (k = 0; k < chars.size(); k++) begin
      expected_chars.push_back('{character: chars[k], last: (k == chars.size() - 1)});
    end
  endfunction

  // directed table entry; empty text means the formatter predicts it
  task automatic add_row(input logic [2:0] cmd, input logic [31:0] val, input string text);
    row_cmd.push_back(cmd);
    row_val.push_back(val);
    row_text.push_back(text);
  endtask

  // presents one transaction, with an optional idle burst ahead of it
  task automatic send_item(input logic [2:0] cmd, input logic [31:0] val, input string text);
    int  gap;
    int  i;
    byte b;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      start_i   <= 1'b0;
      command_i <= 3'($urandom_range(0, 7));
      value_i   <= $urandom;
      repeat (gap) @(posedge clk_i);
    end
    start_i   <= 1'b1;
    command_i <= cmd;
    value_i   <= val;
    do @(posedge clk_i); while (busy_o);
    accepted_count++;
    if (text.len() == 0) begin
      format_chars(cmd, val);
    end else begin
      for (i = 0; i < text.len(); i++) begin
        b = text[i];
        expected_chars.push_back('{character: b[6:0], last: (i == text.len() - 1)});
      end
    end
  endtask

  // random value with a spread of decimal lengths and some extremes
  function automatic logic [31:0] pick_value();
    logic [31:0] corners[8];
    corners = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h0000_8000, 32'h0000_7FFF, 32'h0000_FFFF, 32'h0000_0009};
    case ($urandom_range(0, 7))
      0:       return corners[$urandom_range(0, 7)];
      1, 2, 3: return $urandom >> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  // stimulus
  initial begin : stimulus
    logic [2:0]  cmd;
    logic [31:0] val;
    int          r;
    rst_ni    = 1'b0;
    start_i   = 1'b0;
    command_i = CMD_UDEC16;
    value_i   = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row(CMD_UDEC16, 32'h0000_0000, "0");
    add_row(CMD_UDEC16, 32'h0000_FFFF, "65535");
    add_row(CMD_UDEC16, 32'hFFFF_0001, "1");
    add_row(CMD_SDEC16, 32'h0000_0000, "0");
    add_row(CMD_SDEC16, 32'h0000_7FFF, "32767");
    add_row(CMD_SDEC16, 32'h0000_8000, "-32768");
    add_row(CMD_SDEC16, 32'h0000_FFFF, "-1");
    add_row(CMD_SDEC16, 32'hFFFF_8001, "-32767");
    add_row(CMD_UDEC32, 32'h0000_0000, "0");
    add_row(CMD_UDEC32, 32'hFFFF_FFFF, "4294967295");
    add_row(CMD_UDEC32, 32'd1000000000, "");
    add_row(CMD_UDEC32, 32'd999999999, "");
    add_row(CMD_SDEC32, 32'h7FFF_FFFF, "2147483647");
    add_row(CMD_SDEC32, 32'h8000_0000, "-2147483648");
    add_row(CMD_SDEC32, 32'hFFFF_FFFF, "-1");
    add_row(CMD_HEX16,  32'h0000_0000, "0000");
    add_row(CMD_HEX16,  32'h0000_FFFF, "FFFF");
    add_row(CMD_HEX16,  32'hABCD_1234, "1234");
    add_row(CMD_HEX16,  32'h0000_89AF, "");
    add_row(CMD_BIN16,  32'h0000_0000, "0000000000000000");
    add_row(CMD_BIN16,  32'hFFFF_FFFF, "1111111111111111");
    add_row(CMD_BIN16,  32'h0000_0001, "1000000000000000");
    add_row(CMD_BIN16,  32'hFFFF_8000, "0000000000000001");
    add_row(CMD_SPARE6, 32'h1234_5678, "");
    add_row(CMD_SPARE7, 32'hFFFF_FFFF, "");

    // directed table
    for (r = 0; r < row_cmd.size(); r++) begin
      send_item(row_cmd[r], row_val[r], row_text[r]);
    end

    // hold off until the directed output has drained
    start_i <= 1'b0;
    do @(posedge clk_i); while (expected_chars.size() != 0);

    // random run; unused codes sprinkled in as noise
    while (random_sent < RandomItems) begin
      idle_on = (random_sent < RandomItems - QuietTail) && ((random_sent / 40) % 3 != 2);
      r = $urandom_range(0, 99);
      if (r < 4) begin
        cmd = (r < 2) ? CMD_SPARE6 : CMD_SPARE7;
      end else begin
        cmd = 3'($urandom_range(0, 5));
        random_sent++;
      end
      val = pick_value();
      send_item(cmd, val, "");
    end

    // drain and watch for stray characters
    start_i <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("formatted %0d commands (directed extremes plus random mix) into %0d characters",
             accepted_count, char_count);
    $display("all six formats, ignored codes, sender idle bursts and one full drain pause");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // result checker
  always @(posedge clk_i) begin : check_results
    out_char_t want;
    if (rst_ni && strobe_o) begin
      char_count++;
      if (expected_chars.size() == 0) begin
        $error("character %h with no transaction pending", character_o);
        fail_count++;
      end else begin
        want = expected_chars.pop_front();
        if (character_o !== want.character) begin
          $error("character: expected %h, got %h", want.character, character_o);
          fail_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %b, got %b", want.last, last_o);
          fail_count++;
        end
      end
    end
  end

endmodule
